### rtl/packet_header_parser_macros.svh
// Assertion macros used by the php_parse module of the packet header parser.
`ifndef PACKET_HEADER_PARSER_MACROS_SVH
`define PACKET_HEADER_PARSER_MACROS_SVH

// Checks that cond implies prop in the same cycle.
`define PHP_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Checks that cond implies prop in the following cycle.
`define PHP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/php_pkg.sv
// Types, constants and decode functions shared by the packet header parser.
package php_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRUNC  = 2'd1,
    ST_INDET  = 2'd2,
    ST_BADTAG = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  tag_octet;
    logic [5:0]  pkt_type;
    logic        new_format;
    logic [2:0]  header_length;
    logic [31:0] body_length;
    logic        partial_length;
    status_t     status;
  } result_t;

  localparam logic [7:0] NEW_FMT_MASK   = 8'hC0;
  localparam logic [7:0] LEN_TWO_FIRST  = 8'd192;
  localparam logic [7:0] LEN_TWO_LAST   = 8'd223;
  localparam logic [7:0] LEN_FIVE_MARK  = 8'd255;
  localparam logic [1:0] LEG_LEN_ONE    = 2'd0;
  localparam logic [1:0] LEG_LEN_TWO    = 2'd1;
  localparam logic [1:0] LEG_LEN_INDET  = 2'd3;
  localparam logic [2:0] HDR_LEN_NONE   = 3'd0;
  localparam logic [2:0] HDR_LEN_SHORT  = 3'd2;
  localparam logic [2:0] HDR_LEN_MID    = 3'd3;
  localparam logic [2:0] HDR_LEN_LEGACY = 3'd5;
  localparam logic [2:0] HDR_LEN_LONG   = 3'd6;

  function automatic logic is_new(input logic [7:0] tag);
    is_new = (tag & NEW_FMT_MASK) == NEW_FMT_MASK;
  endfunction

  function automatic logic [5:0] decode_type(input logic [7:0] tag);
    logic [5:0] t;
    t = is_new(tag) ? tag[5:0] : {2'b00, tag[5:2]};
    if ((t >= 6'd1 && t <= 6'd14) || (t >= 6'd17 && t <= 6'd21)) begin
      decode_type = t;
    end else begin
      decode_type = 6'd0;
    end
  endfunction

  function automatic result_t make_result(input logic [7:0] tag, input logic [2:0] hdr,
                                          input logic [31:0] body, input logic partial,
                                          input status_t status);
    result_t r;
    logic    ok_tag;
    ok_tag           = (status != ST_BADTAG);
    r.tag_octet      = tag;
    r.pkt_type       = ok_tag ? decode_type(tag) : 6'd0;
    r.new_format     = ok_tag && is_new(tag);
    r.header_length  = hdr;
    r.body_length    = body;
    r.partial_length = partial;
    r.status         = status;
    make_result      = r;
  endfunction

endpackage

### rtl/php_parse.sv
// Header parsing state machine: consumes one octet per transfer and forms the result.
`include "packet_header_parser_macros.svh"

module php_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             res_valid,
  output php_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN1 = 2'd1,
    PH_MORE = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_tag_r, held_tag_nxt;
  logic [7:0]  flo_r, flo_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  rem_r, rem_nxt;

  logic        done;
  logic [2:0]  need;
  logic [31:0] acc_sh;
  logic [2:0]  rem_dec;
  logic [7:0]  two_hi;
  logic [31:0] two_body;

  always_comb begin
    phase_nxt    = phase_r;
    held_tag_nxt = held_tag_r;
    flo_nxt      = flo_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    res_valid    = 1'b0;
    res          = '0;
    done         = 1'b0;
    need         = 3'd0;
    acc_sh       = {acc_r[23:0], data_byte};
    rem_dec      = ((rem_r == 3'd0) ? 3'd1 : rem_r) - 3'd1;
    two_hi       = flo_r - php_pkg::LEN_TWO_FIRST;
    two_body     = {16'd0, two_hi, 8'd0} + {24'd0, acc_sh[7:0]}
                   + {24'd0, php_pkg::LEN_TWO_FIRST};
    case (phase_r)
      PH_TAG: begin
        if (!data_byte[7]) begin
          res_valid = 1'b1;
          res = php_pkg::make_result(data_byte, php_pkg::HDR_LEN_NONE, 32'd0, 1'b0,
                                     php_pkg::ST_BADTAG);
        end else begin
          held_tag_nxt = data_byte;
          if (!php_pkg::is_new(data_byte) && data_byte[1:0] == php_pkg::LEG_LEN_INDET) begin
            res_valid = 1'b1;
            res = php_pkg::make_result(data_byte, php_pkg::HDR_LEN_NONE, 32'd0, 1'b0,
                                       php_pkg::ST_INDET);
          end else if (last_byte) begin
            res_valid = 1'b1;
            res = php_pkg::make_result(data_byte, php_pkg::HDR_LEN_NONE, 32'd0, 1'b0,
                                       php_pkg::ST_TRUNC);
          end else begin
            phase_nxt = PH_LEN1;
          end
        end
      end
      PH_LEN1: begin
        flo_nxt = data_byte;
        acc_nxt = 32'd0;
        if (php_pkg::is_new(held_tag_r)) begin
          if (data_byte < php_pkg::LEN_TWO_FIRST) begin
            done = 1'b1;
            res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_SHORT,
                                       {24'd0, data_byte}, 1'b0, php_pkg::ST_OK);
          end else if (data_byte <= php_pkg::LEN_TWO_LAST) begin
            need = 3'd1;
          end else if (data_byte == php_pkg::LEN_FIVE_MARK) begin
            need = 3'd4;
          end else begin
            done = 1'b1;
            res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_SHORT,
                                       32'd1 << data_byte[4:0], 1'b1, php_pkg::ST_OK);
          end
        end else begin
          if (held_tag_r[1:0] == php_pkg::LEG_LEN_ONE) begin
            done = 1'b1;
            res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_SHORT,
                                       {24'd0, data_byte}, 1'b0, php_pkg::ST_OK);
          end else if (held_tag_r[1:0] == php_pkg::LEG_LEN_INDET) begin
            done = 1'b1;
            res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_NONE, 32'd0, 1'b0,
                                       php_pkg::ST_INDET);
          end else begin
            acc_nxt = {24'd0, data_byte};
            need = (held_tag_r[1:0] == php_pkg::LEG_LEN_TWO) ? 3'd1 : 3'd3;
          end
        end
        if (done) begin
          res_valid = 1'b1;
        end else if (last_byte) begin
          res_valid = 1'b1;
          res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_NONE, 32'd0, 1'b0,
                                     php_pkg::ST_TRUNC);
        end else begin
          phase_nxt = PH_MORE;
          rem_nxt = need;
        end
      end
      default: begin
        acc_nxt = acc_sh;
        rem_nxt = rem_dec;
        if (rem_dec == 3'd0) begin
          res_valid = 1'b1;
          if (php_pkg::is_new(held_tag_r)) begin
            if (flo_r == php_pkg::LEN_FIVE_MARK) begin
              res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_LONG, acc_sh, 1'b0,
                                         php_pkg::ST_OK);
            end else begin
              res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_MID, two_body, 1'b0,
                                         php_pkg::ST_OK);
            end
          end else begin
            res = php_pkg::make_result(held_tag_r,
                                       (held_tag_r[1:0] == php_pkg::LEG_LEN_TWO) ?
                                       php_pkg::HDR_LEN_MID : php_pkg::HDR_LEN_LEGACY,
                                       acc_sh, 1'b0, php_pkg::ST_OK);
          end
        end else if (last_byte) begin
          res_valid = 1'b1;
          res = php_pkg::make_result(held_tag_r, php_pkg::HDR_LEN_NONE, 32'd0, 1'b0,
                                     php_pkg::ST_TRUNC);
        end
      end
    endcase
    if (res_valid) begin
      phase_nxt = PH_TAG;
      rem_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TAG;
      held_tag_r <= 8'd0;
      flo_r      <= 8'd0;
      acc_r      <= 32'd0;
      rem_r      <= 3'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      held_tag_r <= held_tag_nxt;
      flo_r      <= flo_nxt;
      acc_r      <= acc_nxt;
      rem_r      <= rem_nxt;
    end
  end

  `PHP_ASSERT_NEXT(a_result_restarts, accept && res_valid, phase_r == PH_TAG, "result did not restart header")
  `PHP_ASSERT_IMP(a_count_only_collect, rem_r != 3'd0, phase_r == PH_MORE, "octet count outside collect phase")
  `PHP_ASSERT_IMP(a_ok_has_header, res_valid && res.status == php_pkg::ST_OK, res.header_length != 3'd0, "ok result without header length")
  `PHP_ASSERT_IMP(a_held_tag_valid, phase_r != PH_TAG, held_tag_r[7], "length phase with bad held tag")

endmodule

### rtl/packet_header_parser.sv
// Top level: OpenPGP packet header parser with a registered, skid-buffered result channel.
// The result for the octet that ends a header is registered in the output entry, or
// in the skid entry when the output is stalled. Throughput: one header octet per cycle
// while in_ready is high. The parse state machine and a two-entry output stage set this rate.
// Reset: synchronous, active low; the parser returns to the tag phase and both
// output entries are emptied.
module packet_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tag_octet,
  output logic [5:0]  out_pkt_type,
  output logic        out_new_format,
  output logic [2:0]  out_header_length,
  output logic [31:0] out_body_length,
  output logic        out_partial_length,
  output logic [1:0]  out_status
);

  logic             accept;
  logic             res_valid;
  php_pkg::result_t res;
  logic             push;

  logic             out_valid_r, out_valid_nxt;
  php_pkg::result_t out_r, out_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  php_pkg::result_t skid_r, skid_nxt;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign push     = accept && res_valid;

  php_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_nxt       = res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_tag_octet      = out_r.tag_octet;
  assign out_pkt_type       = out_r.pkt_type;
  assign out_new_format     = out_r.new_format;
  assign out_header_length  = out_r.header_length;
  assign out_body_length    = out_r.body_length;
  assign out_partial_length = out_r.partial_length;
  assign out_status         = out_r.status;

endmodule
